// ----- hw/rtl/bwlp_pkg.sv -----
package bwlp_pkg;

  localparam int WORD_BITS = 32;

  // Operation codes
  localparam logic [3:0] OP_READ   = 4'd0;
  localparam logic [3:0] OP_LOAD   = 4'd1;
  localparam logic [3:0] OP_AND    = 4'd2;
  localparam logic [3:0] OP_OR     = 4'd3;
  localparam logic [3:0] OP_XOR    = 4'd4;
  localparam logic [3:0] OP_ANDNOT = 4'd5;
  localparam logic [3:0] OP_NOT    = 4'd6;
  localparam logic [3:0] OP_COUNT  = 4'd7;
  localparam logic [3:0] OP_CLEAR  = 4'd8;

  // Status codes
  localparam logic STS_OK      = 1'b0;
  localparam logic STS_IDX_ERR = 1'b1;

  typedef logic [WORD_BITS-1:0] word_t;

  // Set-bit count of one word, SWAR style
  function automatic logic [5:0] popcount32(input word_t v);
    word_t a;
    word_t b;
    word_t c;
    word_t d;
    word_t e;
    a = v - ((v >> 1) & 32'h5555_5555);
    b = (a & 32'h3333_3333) + ((a >> 2) & 32'h3333_3333);
    c = (b + (b >> 4)) & 32'h0F0F_0F0F;
    d = c + (c >> 8);
    e = d + (d >> 16);
    return e[5:0];
  endfunction

endpackage

// ----- hw/rtl/bitset_word_logic_popcount.sv -----
// Word operations: memory read, then modify and write back, then output load;
// one item in flight, so the next item is accepted only after the result is loaded.
// Count reads the words in use, one memory read per cycle, summing set bits.
// Clear writes zero to len words, one memory write per cycle.
// After reset a clearing pass zeroes all MAX_WORDS entries, one per cycle,
// with in_stall high; valid_bits resets to 2048.
module bitset_word_logic_popcount #(
  parameter int MAX_WORDS = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [3:0]             in_op,
  input  logic [5:0]             in_word_index,
  input  bwlp_pkg::word_t        in_operand_word,
  input  logic                   in_write_back,
  input  logic [11:0]            in_clear_bits,
  output logic                   out_valid,
  input  logic                   out_stall,
  output bwlp_pkg::word_t        out_result_word,
  output logic [11:0]            out_bit_count,
  output logic                   out_status,
  input  logic                   cfg_wr_en,
  input  logic [11:0]            cfg_wr_data
);
  import bwlp_pkg::*;

  localparam int AW  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int CW  = $clog2(MAX_WORDS + 1);
  localparam int CAP = MAX_WORDS * WORD_BITS;

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_WORD = 3'd2;
  localparam logic [2:0] S_CNT  = 3'd3;
  localparam logic [2:0] S_CLR  = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0]    state_r;
  logic [11:0]   valid_bits_r;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] len_r;
  logic [CW-1:0] ridx_r;
  logic          rv_r;
  logic [11:0]   acc_r;

  logic [3:0]    op_r;
  logic [AW-1:0] addr_r;
  word_t         opnd_r;
  logic          wb_r;
  logic          last_r;

  word_t         st_word_r;
  logic [11:0]   st_cnt_r;
  logic          st_sts_r;

  logic          out_valid_r;
  word_t         out_word_r;
  logic [11:0]   out_cnt_r;
  logic          out_sts_r;

  word_t         mem [MAX_WORDS];
  word_t         rdata_r;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  word_t         mem_wdata;

  // Derived length, words in use and last-word mask
  logic [11:0]   eff_one;
  logic [11:0]   eff;
  logic [7:0]    used_w;
  logic [CW-1:0] used;
  word_t         pad;

  always_comb begin
    eff_one = (valid_bits_r == 12'd0) ? 12'd1 : valid_bits_r;
    eff     = (32'(eff_one) > CAP) ? 12'(CAP) : eff_one;
    used_w  = {1'b0, eff[11:5]} + {7'd0, (eff[4:0] != 5'd0)};
    used    = CW'(used_w);
    pad     = (eff[4:0] == 5'd0) ? '1 : ~(word_t'('1) >> eff[4:0]);
  end

  // Decode the incoming item
  logic          in_acc;
  logic          in_word_op;
  logic          idx_err;
  logic          in_last;
  logic [7:0]    clr_words;
  logic [CW-1:0] clr_len;

  always_comb begin
    in_acc     = in_valid && !in_stall;
    in_word_op = (in_op <= OP_NOT);
    idx_err    = (32'(in_word_index) >= 32'(used));
    in_last    = (32'(in_word_index) == (32'(used) - 32'd1));
    clr_words  = {1'b0, in_clear_bits[11:5]} + 8'd1;
    if (in_clear_bits == 12'd0 || in_clear_bits >= eff ||
        32'(clr_words) >= 32'(used)) begin
      clr_len = used;
    end else begin
      clr_len = CW'(clr_words);
    end
  end

  assign in_stall = (state_r != S_IDLE);

  // Modify the stored word
  word_t word_res;
  logic  word_we;

  always_comb begin
    case (op_r)
      OP_READ:   word_res = rdata_r;
      OP_LOAD:   word_res = opnd_r;
      OP_AND:    word_res = rdata_r & opnd_r;
      OP_OR:     word_res = rdata_r | opnd_r;
      OP_XOR:    word_res = rdata_r ^ opnd_r;
      OP_ANDNOT: word_res = rdata_r & ~opnd_r;
      default:   word_res = ~rdata_r;
    endcase
    if (op_r != OP_READ && last_r) begin
      word_res = word_res & pad;
    end
    word_we = (op_r == OP_LOAD) || (op_r != OP_READ && wb_r);
  end

  // Count lane: mask the last word on its way through
  logic  cnt_last;
  word_t cnt_data;

  always_comb begin
    cnt_last = (32'(ridx_r) == (32'(used) - 32'd1));
    cnt_data = cnt_last ? (rdata_r & pad) : rdata_r;
  end

  // Memory port control
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = cnt_r[AW-1:0];
    mem_we    = 1'b0;
    mem_waddr = cnt_r[AW-1:0];
    mem_wdata = '0;
    unique case (state_r) inside
      S_INIT, S_CLR: begin
        mem_we = 1'b1;
      end
      S_IDLE: begin
        mem_re    = in_acc && in_word_op && !idx_err;
        mem_raddr = AW'(in_word_index);
      end
      S_WORD: begin
        mem_we    = word_we;
        mem_waddr = addr_r;
        mem_wdata = word_res;
      end
      S_CNT: begin
        mem_re    = (cnt_r < used);
        mem_we    = rv_r && cnt_last;
        mem_waddr = ridx_r[AW-1:0];
        mem_wdata = cnt_data;
      end
      default: begin
      end
    endcase
  end

  // Word store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_bits_r <= 12'd2048;
    end else if (cfg_wr_en) begin
      valid_bits_r <= cfg_wr_data;
    end
  end

  // Sequencer
  logic out_load;
  assign out_load = (state_r == S_EMIT) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      cnt_r   <= '0;
      rv_r    <= 1'b0;
    end else begin
      unique case (state_r)
        S_INIT: begin
          cnt_r <= cnt_r + CW'(1);
          if (cnt_r == CW'(MAX_WORDS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            cnt_r <= '0;
            rv_r  <= 1'b0;
            if (in_word_op && !idx_err) begin
              state_r <= S_WORD;
            end else if (in_op == OP_COUNT) begin
              state_r <= S_CNT;
            end else if (in_op == OP_CLEAR) begin
              state_r <= S_CLR;
            end else begin
              state_r <= S_EMIT;
            end
          end
        end
        S_WORD: begin
          state_r <= S_EMIT;
        end
        S_CNT: begin
          if (cnt_r < used) begin
            cnt_r <= cnt_r + CW'(1);
            rv_r  <= 1'b1;
          end else begin
            rv_r <= 1'b0;
            if (!rv_r) begin
              state_r <= S_EMIT;
            end
          end
        end
        S_CLR: begin
          cnt_r <= cnt_r + CW'(1);
          if (cnt_r == len_r - CW'(1)) begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Item and staging payload
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_acc) begin
      op_r      <= in_op;
      addr_r    <= AW'(in_word_index);
      opnd_r    <= in_operand_word;
      wb_r      <= in_write_back;
      last_r    <= in_last;
      len_r     <= clr_len;
      acc_r     <= '0;
      st_word_r <= '0;
      st_cnt_r  <= '0;
      st_sts_r  <= (in_word_op && idx_err) ? STS_IDX_ERR : STS_OK;
    end
    if (state_r == S_WORD) begin
      st_word_r <= word_res;
    end
    if (state_r == S_CNT) begin
      ridx_r <= cnt_r;
      if (rv_r) begin
        acc_r <= acc_r + 12'(popcount32(cnt_data));
      end else if (cnt_r >= used) begin
        st_cnt_r <= acc_r;
      end
    end
  end

  // Output register: drop when taken, load a staged result when free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word_r <= st_word_r;
      out_cnt_r  <= st_cnt_r;
      out_sts_r  <= st_sts_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_word = out_word_r;
  assign out_bit_count   = out_cnt_r;
  assign out_status      = out_sts_r;

endmodule
